### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the TLV parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property checked on every clock, quiet in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition that must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Types, codes and constants of the BER-TLV stream parser.
// ----------------------------------------------------------------------------
package btp_pkg;

	localparam int MAX_TAG_BYTES_C = 4;
	localparam int MAX_LEN_BYTES_C = 4;

	localparam logic [7:0] TAG_MORE_MASK  = 8'h1F;
	localparam logic [7:0] LEN_LONG_BIT   = 8'h80;
	localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

	typedef enum logic [2:0] {
		PH_TAG_FIRST = 3'd0,
		PH_TAG_MORE  = 3'd1,
		PH_LEN_FIRST = 3'd2,
		PH_LEN_MORE  = 3'd3,
		PH_VALUE     = 3'd4,
		PH_ERROR     = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_TAG    = 2'd0,
		ROLE_LEN    = 2'd1,
		ROLE_VALUE  = 2'd2,
		ROLE_IGNORE = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TAG_LONG = 2'd1,
		ERR_BAD_LEN  = 2'd2,
		ERR_TRUNC    = 2'd3
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		role_t       byte_role;
		logic [31:0] element_tag;
		logic [31:0] element_length;
		logic        header_done;
		logic        tag_match;
		logic [31:0] value_offset;
		err_t        error_code;
		logic        buffer_end;
	} result_t;

endpackage

### rtl/btp_if.sv
// ----------------------------------------------------------------------------
// btp_if
// Valid/ready channels of the parser: input bytes, results, configuration.
// ----------------------------------------------------------------------------
interface btp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_role;
	logic [31:0] element_tag;
	logic [31:0] element_length;
	logic        header_done;
	logic        tag_match;
	logic [31:0] value_offset;
	logic [1:0]  error_code;
	logic        buffer_end;

	modport source (
		output valid, output byte_role, output element_tag, output element_length,
		output header_done, output tag_match, output value_offset, output error_code,
		output buffer_end, input ready
	);
	modport sink (
		input valid, input byte_role, input element_tag, input element_length,
		input header_done, input tag_match, input value_offset, input error_code,
		input buffer_end, output ready
	);
endinterface

interface btp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/btp_parse_core.sv
// ----------------------------------------------------------------------------
// btp_parse_core
// Parser state and the single-step update applied to one registered byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btp_parse_core #(
	parameter int MAX_TAG_BYTES_P = btp_pkg::MAX_TAG_BYTES_C,
	parameter int MAX_LEN_BYTES_P = btp_pkg::MAX_LEN_BYTES_C
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  btp_pkg::item_t    item,
	input  logic [31:0]       wanted_tag,
	output btp_pkg::result_t  res
);
	import btp_pkg::*;

	localparam int TCNT_W  = $clog2(MAX_TAG_BYTES_P + 1);
	localparam int LLEFT_W = $clog2(MAX_LEN_BYTES_P + 1);

	phase_t              phase_q, phase_d;
	logic [31:0]         tag_q, tag_d;
	logic [TCNT_W-1:0]   tcnt_q, tcnt_d;
	logic [31:0]         len_q, len_d;
	logic [LLEFT_W-1:0]  lleft_q, lleft_d;
	logic [31:0]         vseen_q, vseen_d;
	err_t                errl_q, errl_d;

	logic [7:0]          b;
	logic [6:0]          len_cnt;
	logic                tag_more;
	logic                tag_too_long;
	logic                len_long;
	logic                len_cnt_bad;
	logic [LLEFT_W-1:0]  lleft_dec;
	logic [31:0]         vseen_inc;
	logic [31:0]         len_shift;
	logic                tag_complete;
	err_t                err;

	assign b            = item.data_byte;
	assign len_cnt      = b[6:0] & LEN_COUNT_MASK[6:0];
	assign tag_more     = (b & TAG_MORE_MASK) == TAG_MORE_MASK;
	assign tag_too_long = tcnt_q >= TCNT_W'(MAX_TAG_BYTES_P);
	assign len_long     = (b & LEN_LONG_BIT) != 8'h00;
	assign len_cnt_bad  = (len_cnt == 7'd0) || (len_cnt > 7'(MAX_LEN_BYTES_P));
	assign lleft_dec    = (lleft_q != '0) ? lleft_q - LLEFT_W'(1) : lleft_q;
	assign vseen_inc    = vseen_q + 32'd1;
	assign len_shift    = {len_q[23:0], b};

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_TAG_FIRST: phase_d = tag_more ? PH_TAG_MORE : PH_LEN_FIRST;
			PH_TAG_MORE: begin
				if (tag_too_long) begin
					phase_d = PH_ERROR;
				end else if ((b & LEN_LONG_BIT) == 8'h00) begin
					phase_d = PH_LEN_FIRST;
				end
			end
			PH_LEN_FIRST: begin
				if (len_long) begin
					phase_d = len_cnt_bad ? PH_ERROR : PH_LEN_MORE;
				end else begin
					phase_d = (b == 8'h00) ? PH_TAG_FIRST : PH_VALUE;
				end
			end
			PH_LEN_MORE: begin
				if (lleft_dec == '0) begin
					phase_d = (len_shift == 32'd0) ? PH_TAG_FIRST : PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (vseen_inc == len_q) begin
					phase_d = PH_TAG_FIRST;
				end
			end
			default: phase_d = PH_ERROR;
		endcase
	end

	// Datapath updates and the result of this byte.
	always_comb begin
		tag_d        = tag_q;
		tcnt_d       = tcnt_q;
		len_d        = len_q;
		lleft_d      = lleft_q;
		vseen_d      = vseen_q;
		errl_d       = errl_q;
		tag_complete = 1'b1;
		err          = ERR_NONE;
		res.byte_role    = ROLE_TAG;
		res.header_done  = 1'b0;
		res.value_offset = 32'd0;
		unique case (phase_q)
			PH_TAG_FIRST: begin
				tag_d        = {24'd0, b};
				tcnt_d       = TCNT_W'(1);
				len_d        = 32'd0;
				lleft_d      = '0;
				vseen_d      = 32'd0;
				tag_complete = !tag_more;
			end
			PH_TAG_MORE: begin
				if (tag_too_long) begin
					err          = ERR_TAG_LONG;
					errl_d       = ERR_TAG_LONG;
					tag_complete = 1'b0;
				end else begin
					tag_d        = {tag_q[23:0], b};
					tcnt_d       = tcnt_q + TCNT_W'(1);
					tag_complete = (b & LEN_LONG_BIT) == 8'h00;
				end
			end
			PH_LEN_FIRST: begin
				res.byte_role = ROLE_LEN;
				if (len_long) begin
					if (len_cnt_bad) begin
						err    = ERR_BAD_LEN;
						errl_d = ERR_BAD_LEN;
					end else begin
						len_d   = 32'd0;
						lleft_d = LLEFT_W'(len_cnt);
					end
				end else begin
					len_d           = {24'd0, b};
					res.header_done = 1'b1;
					vseen_d         = 32'd0;
				end
			end
			PH_LEN_MORE: begin
				res.byte_role = ROLE_LEN;
				len_d         = len_shift;
				lleft_d       = lleft_dec;
				if (lleft_dec == '0) begin
					res.header_done = 1'b1;
					vseen_d         = 32'd0;
				end
			end
			PH_VALUE: begin
				res.byte_role    = ROLE_VALUE;
				res.value_offset = vseen_q;
				vseen_d          = vseen_inc;
			end
			default: begin
				res.byte_role = ROLE_IGNORE;
				tag_complete  = 1'b0;
				err           = errl_q;
			end
		endcase

		// A buffer that stops anywhere but on an element boundary is truncated.
		if (item.last_byte && err == ERR_NONE && phase_d != PH_TAG_FIRST) begin
			err = ERR_TRUNC;
		end

		res.element_tag    = tag_d;
		res.element_length = len_d;
		res.tag_match      = tag_complete && err == ERR_NONE && tag_d == wanted_tag;
		res.error_code     = err;
		res.buffer_end     = item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG_FIRST;
			tag_q   <= 32'd0;
			tcnt_q  <= '0;
			len_q   <= 32'd0;
			lleft_q <= '0;
			vseen_q <= 32'd0;
			errl_q  <= ERR_NONE;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_TAG_FIRST;
				tag_q   <= 32'd0;
				tcnt_q  <= '0;
				len_q   <= 32'd0;
				lleft_q <= '0;
				vseen_q <= 32'd0;
				errl_q  <= ERR_NONE;
			end else begin
				phase_q <= phase_d;
				tag_q   <= tag_d;
				tcnt_q  <= tcnt_d;
				len_q   <= len_d;
				lleft_q <= lleft_d;
				vseen_q <= vseen_d;
				errl_q  <= errl_d;
			end
		end
	end

	`ASSERT_CLK(a_err_sticky, clk, arst_n,
		step && phase_q == PH_ERROR && !item.last_byte |=> phase_q == PH_ERROR)
	`ASSERT_CLK(a_last_clears, clk, arst_n,
		step && item.last_byte |=> phase_q == PH_TAG_FIRST && errl_q == ERR_NONE)
	`ASSERT_NEVER(a_value_len_zero, clk, arst_n, phase_q == PH_VALUE && len_q == 32'd0)
	`ASSERT_CLK(a_error_has_code, clk, arst_n, phase_q == PH_ERROR |-> errl_q != ERR_NONE)

endmodule

### rtl/ber_tlv_stream_parser_top.sv
// ----------------------------------------------------------------------------
// ber_tlv_stream_parser_top
// BER-TLV stream parser: one result item for every input byte.
// ----------------------------------------------------------------------------
// The bytes channel takes one byte of a TLV buffer per item, with last_byte
// marking the final byte. Each byte yields exactly one item on the results
// channel: its role, the tag and length so far, header completion, tag match
// against wanted_tag, the value offset and any error code.
// The cfg channel writes wanted_tag; it is always ready and should be used
// only while no byte is in flight.
// An accepted byte lands in an input register, the parser step runs on it
// and its result is registered in the result register, which offers it on
// the results channel. One byte per cycle is sustained while the receiver
// takes results, since each byte updates the parser state in one step.
// When the receiver stalls, the result register holds and the input
// register still takes one more byte; further bytes wait on bytes.ready.
// After the last byte of a buffer the parser state returns to the start of
// a new buffer. Reset clears the parser state, the valid flags of both
// pipeline stages and wanted_tag.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser_top #(
	parameter int MAX_TAG_BYTES_P = btp_pkg::MAX_TAG_BYTES_C,
	parameter int MAX_LEN_BYTES_P = btp_pkg::MAX_LEN_BYTES_C
) (
	input  logic          clk,
	input  logic          arst_n,
	btp_byte_if.sink      bytes,
	btp_result_if.source  results,
	btp_cfg_if.sink       cfg
);
	import btp_pkg::*;

	logic        v_s1, v_s2;
	item_t       item_s1;
	result_t     res_s2;
	result_t     res;
	logic [31:0] wanted_q;
	logic        adv;
	logic        step;

	assign adv         = !v_s2 || results.ready;
	assign bytes.ready = !v_s1 || adv;
	assign step        = v_s1 && adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= 32'd0;
		end else if (cfg.valid) begin
			wanted_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (bytes.ready) begin
				v_s1 <= bytes.valid;
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.data_byte <= bytes.data_byte;
			item_s1.last_byte <= bytes.last_byte;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	btp_parse_core #(
		.MAX_TAG_BYTES_P(MAX_TAG_BYTES_P),
		.MAX_LEN_BYTES_P(MAX_LEN_BYTES_P)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.wanted_tag (wanted_q),
		.res        (res)
	);

	assign results.valid          = v_s2;
	assign results.byte_role      = res_s2.byte_role;
	assign results.element_tag    = res_s2.element_tag;
	assign results.element_length = res_s2.element_length;
	assign results.header_done    = res_s2.header_done;
	assign results.tag_match      = res_s2.tag_match;
	assign results.value_offset   = res_s2.value_offset;
	assign results.error_code     = res_s2.error_code;
	assign results.buffer_end     = res_s2.buffer_end;

endmodule
